// ===== design/ofmb_pkg.sv =====
// ----------------------------------------------------------------------------
// ofmb_pkg
// Shared types and constants for the output fault monitor and blinker.
// ----------------------------------------------------------------------------
`default_nettype none

package ofmb_pkg;

    localparam int MV_W      = 16;
    localparam int CODE_W    = 4;
    localparam int CNT_W     = 4;
    localparam int BLANK_W   = 2;
    localparam int IDX_W     = 7;
    localparam int CFG_IDX_W = 3;

    localparam int BLANK_SAMPLES_DEF = 3;

    localparam logic [CNT_W-1:0] PERSIST_LIMIT    = CNT_W'(8);
    localparam logic [IDX_W-1:0] LEAD_STEPS       = IDX_W'(5);
    localparam logic [IDX_W-1:0] LEAD_COLOR_STEPS = IDX_W'(3);
    localparam logic [IDX_W-1:0] STEPS_PER_CODE   = IDX_W'(6);
    localparam logic [IDX_W-1:0] CYCLE_BASE       = IDX_W'(15);

    typedef enum logic [1:0] {
        OP_MONITOR = 2'd0,
        OP_TICK    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_REPORT  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVP_CELL   = 3'd0,
        CFG_SHORT_OUT  = 3'd1,
        CFG_SHORT_FB   = 3'd2,
        CFG_OPEN_FB    = 3'd3,
        CFG_OPEN_OUT   = 3'd4,
        CFG_OPEN_CODE  = 3'd5,
        CFG_SHORT_CODE = 3'd6,
        CFG_OVP_CODE   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        LED_OFF    = 2'd0,
        LED_RED    = 2'd1,
        LED_YELLOW = 2'd2,
        LED_GREEN  = 2'd3
    } led_t;

    typedef struct packed {
        op_t               operation;
        logic              output_enabled;
        logic [MV_W-1:0]   cell_mv;
        logic [MV_W-1:0]   out_mv;
        logic [MV_W-1:0]   fb_mv;
        logic [CODE_W-1:0] external_code;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] fault_code;
        logic              fault_active;
        logic              fault_fatal;
        logic [1:0]        led_state;
        logic [CNT_W-1:0]  fault_counter;
    } result_t;

    typedef struct packed {
        logic [MV_W-1:0]   ovp_cell_mv;
        logic [MV_W-1:0]   short_out_mv;
        logic [MV_W-1:0]   short_fb_mv;
        logic [MV_W-1:0]   open_fb_mv;
        logic [MV_W-1:0]   open_out_mv;
        logic [CODE_W-1:0] open_fault_code;
        logic [CODE_W-1:0] short_fault_code;
        logic [CODE_W-1:0] ovp_fault_code;
    } cfg_t;

endpackage

`default_nettype wire

// ===== design/ofmb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ofmb_cfg_regs
// Threshold and fault code registers, written one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ofmb_cfg_regs
    import ofmb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [MV_W-1:0]      wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_OVP_CELL:   cfg_next.ovp_cell_mv      = wr_data;
                CFG_SHORT_OUT:  cfg_next.short_out_mv     = wr_data;
                CFG_SHORT_FB:   cfg_next.short_fb_mv      = wr_data;
                CFG_OPEN_FB:    cfg_next.open_fb_mv       = wr_data;
                CFG_OPEN_OUT:   cfg_next.open_out_mv      = wr_data;
                CFG_OPEN_CODE:  cfg_next.open_fault_code  = wr_data[CODE_W-1:0];
                CFG_SHORT_CODE: cfg_next.short_fault_code = wr_data[CODE_W-1:0];
                CFG_OVP_CODE:   cfg_next.ovp_fault_code   = wr_data[CODE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ovp_cell_mv      <= MV_W'(4400);
            cfg_reg.short_out_mv     <= MV_W'(19000);
            cfg_reg.short_fb_mv      <= MV_W'(4800);
            cfg_reg.open_fb_mv       <= MV_W'(500);
            cfg_reg.open_out_mv      <= MV_W'(32800);
            cfg_reg.open_fault_code  <= CODE_W'(1);
            cfg_reg.short_fault_code <= CODE_W'(2);
            cfg_reg.ovp_fault_code   <= CODE_W'(3);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/ofmb_core.sv =====
// ----------------------------------------------------------------------------
// ofmb_core
// Fault state update and result decode for one item per cycle while fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ofmb_core
    import ofmb_pkg::*;
#(
    parameter int BLANK_SAMPLES = BLANK_SAMPLES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    localparam logic [BLANK_W-1:0] BLANK_LIMIT = BLANK_W'(BLANK_SAMPLES);

    logic [BLANK_W-1:0] blank_count_reg, blank_count_next;
    logic [CNT_W-1:0]   persist_count_reg, persist_count_next;
    logic               last_kind_open_reg, last_kind_open_next;
    logic [CODE_W-1:0]  latched_code_reg, latched_code_next;
    logic [IDX_W-1:0]   display_index_reg, display_index_next;

    logic [IDX_W-1:0]   idx_inc;
    logic [IDX_W-1:0]   cycle_len;
    logic [IDX_W-1:0]   blink_end;
    logic [IDX_W-1:0]   blink_off;
    logic [14:0]        third_prod;
    logic [1:0]         led;
    logic               is_short;
    logic               is_open;

    assign is_short = (item.out_mv < cfg.short_out_mv) && (item.fb_mv > cfg.short_fb_mv);
    assign is_open  = (item.fb_mv < cfg.open_fb_mv) && (item.out_mv > cfg.open_out_mv);
    assign idx_inc  = display_index_reg + IDX_W'(1);
    assign cycle_len = CYCLE_BASE + IDX_W'(latched_code_reg) * STEPS_PER_CODE;

    always_comb
    begin
        blank_count_next    = blank_count_reg;
        persist_count_next  = persist_count_reg;
        last_kind_open_next = last_kind_open_reg;
        latched_code_next   = latched_code_reg;
        display_index_next  = display_index_reg;
        unique case (item.operation)
            OP_MONITOR:
            begin
                if (!item.output_enabled)
                begin
                    blank_count_next = '0;
                end
                else if (blank_count_reg < BLANK_LIMIT)
                begin
                    blank_count_next = blank_count_reg + BLANK_W'(1);
                end
                else
                begin
                    if (item.cell_mv > cfg.ovp_cell_mv)
                        latched_code_next = cfg.ovp_fault_code;
                    if (is_short)
                    begin
                        persist_count_next = (persist_count_reg < PERSIST_LIMIT) ?
                                             persist_count_reg + CNT_W'(2) : PERSIST_LIMIT;
                        last_kind_open_next = 1'b0;
                    end
                    else if (is_open)
                    begin
                        persist_count_next = (persist_count_reg < PERSIST_LIMIT) ?
                                             persist_count_reg + CNT_W'(1) : PERSIST_LIMIT;
                        last_kind_open_next = 1'b1;
                    end
                    else if (persist_count_reg != '0)
                    begin
                        persist_count_next = persist_count_reg - CNT_W'(1);
                    end
                    if (persist_count_next >= PERSIST_LIMIT)
                        latched_code_next = last_kind_open_next ? cfg.open_fault_code
                                                                : cfg.short_fault_code;
                end
            end
            OP_TICK:
            begin
                if (latched_code_reg == '0)
                    display_index_next = '0;
                else if (idx_inc >= cycle_len)
                    display_index_next = '0;
                else
                    display_index_next = idx_inc;
            end
            OP_CLEAR:  latched_code_next = '0;
            OP_REPORT: latched_code_next = item.external_code;
            default:   latched_code_next = latched_code_reg;
        endcase
    end

    // blink phase: (idx - 5) / 3 via reciprocal 171/512, exact for 7-bit values
    assign blink_end  = LEAD_STEPS + IDX_W'(latched_code_next) * STEPS_PER_CODE;
    assign blink_off  = display_index_next - LEAD_STEPS;
    assign third_prod = {8'd0, blink_off} * 15'd171;

    always_comb
    begin
        if (latched_code_next == '0)
            led = LED_OFF;
        else if (display_index_next < LEAD_STEPS)
            led = (display_index_next < LEAD_COLOR_STEPS) ?
                  display_index_next[1:0] + 2'd1 : LED_OFF;
        else if (display_index_next < blink_end)
            led = third_prod[9] ? LED_OFF : LED_RED;
        else
            led = LED_OFF;
    end

    always_comb
    begin
        result.fault_code    = latched_code_next;
        result.fault_active  = (latched_code_next != '0);
        result.fault_fatal   = (latched_code_next != '0) &&
                               (latched_code_next != cfg.open_fault_code) &&
                               (latched_code_next != cfg.short_fault_code) &&
                               (latched_code_next != cfg.ovp_fault_code);
        result.led_state     = led;
        result.fault_counter = persist_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_count_reg    <= '0;
            persist_count_reg  <= '0;
            last_kind_open_reg <= 1'b0;
            latched_code_reg   <= '0;
            display_index_reg  <= '0;
        end
        else if (fire)
        begin
            blank_count_reg    <= blank_count_next;
            persist_count_reg  <= persist_count_next;
            last_kind_open_reg <= last_kind_open_next;
            latched_code_reg   <= latched_code_next;
            display_index_reg  <= display_index_next;
        end
    end

    ap_persist_range: assert property (@(posedge clk) disable iff (!rst_n)
        persist_count_reg <= CNT_W'(9))
        else $error("persistence counter out of range");

    ap_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        display_index_reg < IDX_W'(105))
        else $error("display index beyond longest cycle");

    ap_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.operation == OP_CLEAR |=> latched_code_reg == '0)
        else $error("clear did not drop the fault code");

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(latched_code_reg) && $stable(persist_count_reg))
        else $error("fault state changed without a transfer");

endmodule

`default_nettype wire

// ===== design/output_fault_monitor_blinker.sv =====
// ----------------------------------------------------------------------------
// output_fault_monitor_blinker
// Converter fault monitor with persistence counter and blink-code indicator.
// ----------------------------------------------------------------------------
// Accepts one item per clock unless a waiting result is not taken: an item
// is captured in an input register, the fault state update and result
// decode run when it advances, and the result sits in an output register
// until taken. Throughput is one item per cycle while results are taken,
// set by the state update loop. Configuration writes are taken every cycle
// and must only be issued while no item is in flight.
`default_nettype none

module output_fault_monitor_blinker
    import ofmb_pkg::*;
#(
    parameter int BLANK_SAMPLES = BLANK_SAMPLES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire item_t                in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output result_t                   out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MV_W-1:0]      cfg_data
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;
    cfg_t    cfg;
    result_t core_result;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    ofmb_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ofmb_core #(
        .BLANK_SAMPLES (BLANK_SAMPLES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_data;
        if (advance)
            out_reg <= core_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
